[rtl/core/lav_pkg.sv]
`timescale 1ns / 1ps
// lav_pkg: shared types and constants of the look-at view matrix block.
// No dependencies.
package lav_pkg;

  localparam int LAV_FRAC_BITS  = 16;
  localparam int LAV_COL_W      = 32;
  localparam int LAV_DIFF_W     = 33;
  localparam int LAV_PROD_W     = 64;
  localparam int LAV_MAG_W      = 30;
  localparam int LAV_NORM_MSB   = 29;
  localparam int LAV_SUM_W      = 62;
  localparam int LAV_LEN_W      = 31;
  localparam int LAV_SQ_W       = 64;
  localparam int LAV_SQ_TOP     = 62;
  localparam int LAV_SQ_STEPS   = 32;
  localparam int LAV_STEPS_PER  = 2;
  localparam int LAV_ROW_W      = 2;

  localparam logic [LAV_ROW_W-1:0] LAV_ROW_LAST = 2'd2;

  typedef struct packed {
    logic signed [LAV_COL_W-1:0] eye_x;
    logic signed [LAV_COL_W-1:0] eye_y;
    logic signed [LAV_COL_W-1:0] eye_z;
    logic signed [LAV_COL_W-1:0] aim_x;
    logic signed [LAV_COL_W-1:0] aim_y;
    logic signed [LAV_COL_W-1:0] aim_z;
    logic signed [LAV_COL_W-1:0] upward_x;
    logic signed [LAV_COL_W-1:0] upward_y;
    logic signed [LAV_COL_W-1:0] upward_z;
  } lav_in_t;

  typedef struct packed {
    logic [LAV_ROW_W-1:0]        row_index;
    logic signed [LAV_COL_W-1:0] col_a;
    logic signed [LAV_COL_W-1:0] col_b;
    logic signed [LAV_COL_W-1:0] col_c;
    logic signed [LAV_COL_W-1:0] col_d;
    logic                        degenerate;
    logic                        is_last;
  } lav_out_t;

endpackage

[rtl/core/look_at_view_matrix.sv]
`timescale 1ns / 1ps
// look_at_view_matrix: look-at view matrix builder, top level.
// Depends on lav_pkg and lav_norm.
//
// Each input transaction (eye, target, up; signed fixed point with FRAC_BITS
// fraction bits) yields three output transactions, rows 0..2 of the view
// matrix, is_last on row 2. The pipeline takes a new transaction every cycle
// while the output register is free; since the single output channel moves
// one row per cycle while out_stall is low, a new transaction is taken only
// as the last row of the held one leaves. Each input passes three chained
// normalizers, each a 2-bit-per-stage integer square root followed by a
// 2-bit-per-stage divide.
module look_at_view_matrix #(
  parameter int FRAC_BITS = lav_pkg::LAV_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lav_pkg::lav_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lav_pkg::lav_out_t out_data
);
  import lav_pkg::*;

  localparam int UW = FRAC_BITS + 2;
  localparam logic [LAV_PROD_W-1:0] RND_HALF = LAV_PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [LAV_PROD_W-1:0] SAT_POS  = LAV_PROD_W'(32'h7FFF_FFFF);
  localparam logic [LAV_PROD_W-1:0] SAT_NEG  = LAV_PROD_W'(32'h8000_0000);

  typedef logic [2:0][LAV_COL_W-1:0] coord_t;
  typedef logic [2:0][UW-1:0]        axis_t;

  typedef struct packed {
    coord_t eye;
    coord_t up;
  } sd1_t;

  typedef struct packed {
    coord_t eye;
    axis_t  f;
    logic   okf;
  } sd2_t;

  typedef struct packed {
    coord_t eye;
    axis_t  f;
    logic   okf;
    axis_t  s;
    logic   oks;
  } sd3_t;

  logic adv;

  // input register
  logic                         p0_vld_r;
  logic signed [LAV_DIFF_W-1:0] p0_d_r [3];
  sd1_t                         p0_sd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else if (adv) begin
      p0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_d_r[0]  <= LAV_DIFF_W'(in_data.aim_x) - LAV_DIFF_W'(in_data.eye_x);
      p0_d_r[1]  <= LAV_DIFF_W'(in_data.aim_y) - LAV_DIFF_W'(in_data.eye_y);
      p0_d_r[2]  <= LAV_DIFF_W'(in_data.aim_z) - LAV_DIFF_W'(in_data.eye_z);
      p0_sd_r.eye <= {in_data.eye_z, in_data.eye_y, in_data.eye_x};
      p0_sd_r.up  <= {in_data.upward_z, in_data.upward_y, in_data.upward_x};
    end
  end

  // forward axis
  logic                 n1_vld, n1_ok;
  logic signed [UW-1:0] n1_vec [3];
  sd1_t                 n1_sd;

  lav_norm #(
    .W  (LAV_DIFF_W),
    .FB (FRAC_BITS),
    .SW ($bits(sd1_t))
  ) u_norm_f (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (p0_vld_r),
    .in_vec   (p0_d_r),
    .in_side  (p0_sd_r),
    .out_vld  (n1_vld),
    .out_vec  (n1_vec),
    .out_ok   (n1_ok),
    .out_side (n1_sd)
  );

  // right axis = f x up
  logic signed [LAV_COL_W-1:0]  up_c [3];
  axis_t                        n1_f_c;
  logic                         xa_vld_r, xb_vld_r;
  logic signed [LAV_PROD_W-1:0] xa_p_r [6];
  logic signed [LAV_PROD_W-1:0] xb_c_r [3];
  sd2_t                         xa_sd_r, xb_sd_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up_c[i]   = $signed(n1_sd.up[i]);
      n1_f_c[i] = n1_vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xa_vld_r <= 1'b0;
      xb_vld_r <= 1'b0;
    end else if (adv) begin
      xa_vld_r <= n1_vld;
      xb_vld_r <= xa_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xa_p_r[0] <= LAV_PROD_W'(n1_vec[1]) * LAV_PROD_W'(up_c[2]);
      xa_p_r[1] <= LAV_PROD_W'(n1_vec[2]) * LAV_PROD_W'(up_c[1]);
      xa_p_r[2] <= LAV_PROD_W'(n1_vec[2]) * LAV_PROD_W'(up_c[0]);
      xa_p_r[3] <= LAV_PROD_W'(n1_vec[0]) * LAV_PROD_W'(up_c[2]);
      xa_p_r[4] <= LAV_PROD_W'(n1_vec[0]) * LAV_PROD_W'(up_c[1]);
      xa_p_r[5] <= LAV_PROD_W'(n1_vec[1]) * LAV_PROD_W'(up_c[0]);
      xa_sd_r.eye <= n1_sd.eye;
      xa_sd_r.f   <= n1_f_c;
      xa_sd_r.okf <= n1_ok;
      xb_c_r[0] <= xa_p_r[0] - xa_p_r[1];
      xb_c_r[1] <= xa_p_r[2] - xa_p_r[3];
      xb_c_r[2] <= xa_p_r[4] - xa_p_r[5];
      xb_sd_r   <= xa_sd_r;
    end
  end

  logic                 n2_vld, n2_ok;
  logic signed [UW-1:0] n2_vec [3];
  sd2_t                 n2_sd;

  lav_norm #(
    .W  (LAV_PROD_W),
    .FB (FRAC_BITS),
    .SW ($bits(sd2_t))
  ) u_norm_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (xb_vld_r),
    .in_vec   (xb_c_r),
    .in_side  (xb_sd_r),
    .out_vld  (n2_vld),
    .out_vec  (n2_vec),
    .out_ok   (n2_ok),
    .out_side (n2_sd)
  );

  // true up = s x f
  logic signed [UW-1:0]         f2_c [3];
  axis_t                        n2_s_c;
  logic                         ya_vld_r, yb_vld_r;
  logic signed [LAV_PROD_W-1:0] ya_p_r [6];
  logic signed [LAV_PROD_W-1:0] yb_c_r [3];
  sd3_t                         ya_sd_r, yb_sd_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f2_c[i]   = $signed(n2_sd.f[i]);
      n2_s_c[i] = n2_vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ya_vld_r <= 1'b0;
      yb_vld_r <= 1'b0;
    end else if (adv) begin
      ya_vld_r <= n2_vld;
      yb_vld_r <= ya_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ya_p_r[0] <= LAV_PROD_W'(n2_vec[1]) * LAV_PROD_W'(f2_c[2]);
      ya_p_r[1] <= LAV_PROD_W'(n2_vec[2]) * LAV_PROD_W'(f2_c[1]);
      ya_p_r[2] <= LAV_PROD_W'(n2_vec[2]) * LAV_PROD_W'(f2_c[0]);
      ya_p_r[3] <= LAV_PROD_W'(n2_vec[0]) * LAV_PROD_W'(f2_c[2]);
      ya_p_r[4] <= LAV_PROD_W'(n2_vec[0]) * LAV_PROD_W'(f2_c[1]);
      ya_p_r[5] <= LAV_PROD_W'(n2_vec[1]) * LAV_PROD_W'(f2_c[0]);
      ya_sd_r.eye <= n2_sd.eye;
      ya_sd_r.f   <= n2_sd.f;
      ya_sd_r.okf <= n2_sd.okf;
      ya_sd_r.s   <= n2_s_c;
      ya_sd_r.oks <= n2_ok;
      yb_c_r[0] <= ya_p_r[0] - ya_p_r[1];
      yb_c_r[1] <= ya_p_r[2] - ya_p_r[3];
      yb_c_r[2] <= ya_p_r[4] - ya_p_r[5];
      yb_sd_r   <= ya_sd_r;
    end
  end

  logic                 n3_vld, n3_ok;
  logic signed [UW-1:0] n3_vec [3];
  sd3_t                 n3_sd;

  lav_norm #(
    .W  (LAV_PROD_W),
    .FB (FRAC_BITS),
    .SW ($bits(sd3_t))
  ) u_norm_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (yb_vld_r),
    .in_vec   (yb_c_r),
    .in_side  (yb_sd_r),
    .out_vld  (n3_vld),
    .out_vec  (n3_vec),
    .out_ok   (n3_ok),
    .out_side (n3_sd)
  );

  // rows and translation; row 2 product uses +f so its sum needs no negate
  logic signed [UW-1:0]         rw_c  [3][3];
  logic                         ok_c  [3];
  logic signed [LAV_COL_W-1:0]  eye_c [3];
  logic                         t1_vld_r, t2_vld_r, t3_vld_r, t4_vld_r;
  logic signed [LAV_PROD_W-1:0] t1_p_r [3][3];
  logic signed [LAV_PROD_W-1:0] t2_t_r [3];
  logic [LAV_PROD_W-1:0]        t3_mag_r [3];
  logic [2:0]                   t3_neg_r;
  logic [LAV_PROD_W-1:0]        rnd_c [3];
  logic signed [LAV_COL_W-1:0]  cd_c  [3];
  lav_out_t                     t1_o_r [3];
  lav_out_t                     t2_o_r [3];
  lav_out_t                     t3_o_r [3];
  lav_out_t                     t4_o_nxt [3];
  lav_out_t                     t4_o_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rw_c[0][i] = $signed(n3_sd.s[i]);
      rw_c[1][i] = n3_vec[i];
      rw_c[2][i] = $signed(n3_sd.f[i]);
      eye_c[i]   = $signed(n3_sd.eye[i]);
    end
    ok_c[0] = n3_sd.oks;
    ok_c[1] = n3_ok;
    ok_c[2] = n3_sd.okf;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rnd_c[r] = (t3_mag_r[r] + RND_HALF) >> FRAC_BITS;
      if (!t3_neg_r[r] && rnd_c[r] > SAT_POS) begin
        cd_c[r] = LAV_COL_W'(SAT_POS);
      end else if (t3_neg_r[r] && rnd_c[r] > SAT_NEG) begin
        cd_c[r] = LAV_COL_W'(SAT_NEG);
      end else if (t3_neg_r[r]) begin
        cd_c[r] = -rnd_c[r][LAV_COL_W-1:0];
      end else begin
        cd_c[r] = rnd_c[r][LAV_COL_W-1:0];
      end
      t4_o_nxt[r]       = t3_o_r[r];
      t4_o_nxt[r].col_d = t3_o_r[r].degenerate ? '0 : cd_c[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
      t3_vld_r <= 1'b0;
      t4_vld_r <= 1'b0;
    end else if (adv) begin
      t1_vld_r <= n3_vld;
      t2_vld_r <= t1_vld_r;
      t3_vld_r <= t2_vld_r;
      t4_vld_r <= t3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          t1_p_r[r][i] <= LAV_PROD_W'(rw_c[r][i]) * LAV_PROD_W'(eye_c[i]);
        end
        t1_o_r[r].row_index  <= LAV_ROW_W'(r);
        t1_o_r[r].degenerate <= !ok_c[r];
        t1_o_r[r].is_last    <= (LAV_ROW_W'(r) == LAV_ROW_LAST);
        t1_o_r[r].col_d      <= '0;
        if (!ok_c[r]) begin
          t1_o_r[r].col_a <= '0;
          t1_o_r[r].col_b <= '0;
          t1_o_r[r].col_c <= '0;
        end else if (LAV_ROW_W'(r) == LAV_ROW_LAST) begin
          t1_o_r[r].col_a <= LAV_COL_W'(-rw_c[r][0]);
          t1_o_r[r].col_b <= LAV_COL_W'(-rw_c[r][1]);
          t1_o_r[r].col_c <= LAV_COL_W'(-rw_c[r][2]);
        end else begin
          t1_o_r[r].col_a <= LAV_COL_W'(rw_c[r][0]);
          t1_o_r[r].col_b <= LAV_COL_W'(rw_c[r][1]);
          t1_o_r[r].col_c <= LAV_COL_W'(rw_c[r][2]);
        end

        if (LAV_ROW_W'(r) == LAV_ROW_LAST) begin
          t2_t_r[r] <= t1_p_r[r][0] + t1_p_r[r][1] + t1_p_r[r][2];
        end else begin
          t2_t_r[r] <= -(t1_p_r[r][0] + t1_p_r[r][1] + t1_p_r[r][2]);
        end
        t2_o_r[r] <= t1_o_r[r];

        t3_neg_r[r] <= t2_t_r[r][LAV_PROD_W-1];
        t3_mag_r[r] <= t2_t_r[r][LAV_PROD_W-1] ? LAV_PROD_W'(-t2_t_r[r])
                                               : LAV_PROD_W'(t2_t_r[r]);
        t3_o_r[r] <= t2_o_r[r];

        t4_o_r[r] <= t4_o_nxt[r];
      end
    end
  end

  // output register: holds one matrix, sends one row per transaction
  logic                 out_vld_r;
  logic [LAV_ROW_W-1:0] row_r;
  lav_out_t             mat_r [3];

  assign adv = !out_vld_r || (!out_stall && row_r == LAV_ROW_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      row_r     <= '0;
    end else if (adv) begin
      out_vld_r <= t4_vld_r;
      row_r     <= '0;
    end else if (!out_stall) begin
      row_r <= row_r + LAV_ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && t4_vld_r) begin
      mat_r <= t4_o_r;
    end
  end

  assign in_stall  = !adv;
  assign out_valid = out_vld_r;
  assign out_data  = mat_r[row_r];

endmodule

[rtl/core/lav_norm.sv]
`timescale 1ns / 1ps
// lav_norm: pipelined 3-vector normalizer (pre-scale, integer sqrt, restoring divide).
// Depends on lav_pkg.
module lav_norm #(
  parameter int W  = lav_pkg::LAV_DIFF_W,
  parameter int FB = lav_pkg::LAV_FRAC_BITS,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [W-1:0]  in_vec [3],
  input  logic [SW-1:0]        in_side,
  output logic                 out_vld,
  output logic signed [FB+1:0] out_vec [3],
  output logic                 out_ok,
  output logic [SW-1:0]        out_side
);
  import lav_pkg::*;

  localparam int PW = $clog2(W);
  localparam int UW = FB + 2;
  localparam int NW = FB + LAV_LEN_W;
  localparam int QS = LAV_SQ_STEPS / LAV_STEPS_PER;
  localparam int DS = (FB + LAV_STEPS_PER) / LAV_STEPS_PER;

  function automatic logic [PW-1:0] msb_pos(input logic [W-1:0] v);
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < W; i++) begin
      if (v[i]) begin
        p = PW'(i);
      end
    end
    return p;
  endfunction

  logic                 a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r, o_vld_r;
  logic [W-1:0]         a_mag_r [3];
  logic [W-1:0]         b_mag_r [3];
  logic [W-1:0]         c_mag_r [3];
  logic [2:0]           a_neg_r, b_neg_r, c_neg_r, d_neg_r, e_neg_r;
  logic [SW-1:0]        a_sd_r, b_sd_r, c_sd_r, d_sd_r, e_sd_r, o_sd_r;
  logic [W-1:0]         top_c;
  logic [W-1:0]         b_top_r;
  logic [PW-1:0]        c_msb_r;
  logic                 c_zero_r, d_zero_r, e_zero_r, o_ok_r;
  logic [LAV_MAG_W-1:0] m_c   [3];
  logic [LAV_MAG_W-1:0] d_m_r [3];
  logic [LAV_MAG_W-1:0] e_m_r [3];
  logic [LAV_SUM_W-1:0] e_sq_r [3];

  logic                 sq_vld_r  [QS+1];
  logic [LAV_SQ_W-1:0]  sq_x_r    [QS+1];
  logic [LAV_SQ_W-1:0]  sq_q_r    [QS+1];
  logic [LAV_MAG_W-1:0] sq_m_r    [QS+1][3];
  logic [2:0]           sq_neg_r  [QS+1];
  logic                 sq_zero_r [QS+1];
  logic [SW-1:0]        sq_sd_r   [QS+1];

  logic                 dv_vld_r  [DS+1];
  logic [NW-1:0]        dv_rem_r  [DS+1][3];
  logic [FB:0]          dv_q_r    [DS+1][3];
  logic [LAV_LEN_W-1:0] dv_len_r  [DS+1];
  logic [2:0]           dv_neg_r  [DS+1];
  logic                 dv_zero_r [DS+1];
  logic [SW-1:0]        dv_sd_r   [DS+1];

  logic [LAV_LEN_W-1:0] len_c;
  logic [UW-1:0]        qx_c [3];
  logic signed [UW-1:0] o_vec_r [3];

  always_comb begin
    top_c = a_mag_r[0];
    if (a_mag_r[1] > top_c) begin
      top_c = a_mag_r[1];
    end
    if (a_mag_r[2] > top_c) begin
      top_c = a_mag_r[2];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (c_msb_r >= PW'(LAV_NORM_MSB)) begin
        m_c[i] = LAV_MAG_W'(c_mag_r[i] >> (c_msb_r - PW'(LAV_NORM_MSB)));
      end else begin
        m_c[i] = LAV_MAG_W'(c_mag_r[i] << (PW'(LAV_NORM_MSB) - c_msb_r));
      end
    end
  end

  assign len_c = sq_q_r[QS][LAV_LEN_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx_c[i] = {1'b0, dv_q_r[DS][i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      e_vld_r     <= 1'b0;
      sq_vld_r[0] <= 1'b0;
      dv_vld_r[0] <= 1'b0;
      o_vld_r     <= 1'b0;
    end else if (en) begin
      a_vld_r     <= in_vld;
      b_vld_r     <= a_vld_r;
      c_vld_r     <= b_vld_r;
      d_vld_r     <= c_vld_r;
      e_vld_r     <= d_vld_r;
      sq_vld_r[0] <= e_vld_r;
      dv_vld_r[0] <= sq_vld_r[QS];
      o_vld_r     <= dv_vld_r[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_mag_r[i]     <= in_vec[i][W-1] ? W'(-in_vec[i]) : W'(in_vec[i]);
        a_neg_r[i]     <= in_vec[i][W-1];
        b_mag_r[i]     <= a_mag_r[i];
        c_mag_r[i]     <= b_mag_r[i];
        d_m_r[i]       <= m_c[i];
        e_m_r[i]       <= d_m_r[i];
        e_sq_r[i]      <= LAV_SUM_W'(d_m_r[i]) * LAV_SUM_W'(d_m_r[i]);
        sq_m_r[0][i]   <= e_m_r[i];
        dv_rem_r[0][i] <= (NW'(sq_m_r[QS][i]) << FB) + NW'(len_c >> 1);
        dv_q_r[0][i]   <= '0;
        o_vec_r[i]     <= dv_zero_r[DS] ? '0 : (dv_neg_r[DS][i] ? -qx_c[i] : qx_c[i]);
      end
      a_sd_r       <= in_side;
      b_sd_r       <= a_sd_r;
      b_neg_r      <= a_neg_r;
      b_top_r      <= top_c;
      c_sd_r       <= b_sd_r;
      c_neg_r      <= b_neg_r;
      c_msb_r      <= msb_pos(b_top_r);
      c_zero_r     <= (b_top_r == '0);
      d_sd_r       <= c_sd_r;
      d_neg_r      <= c_neg_r;
      d_zero_r     <= c_zero_r;
      e_sd_r       <= d_sd_r;
      e_neg_r      <= d_neg_r;
      e_zero_r     <= d_zero_r;
      sq_x_r[0]    <= LAV_SQ_W'(e_sq_r[0] + e_sq_r[1] + e_sq_r[2]);
      sq_q_r[0]    <= '0;
      sq_neg_r[0]  <= e_neg_r;
      sq_zero_r[0] <= e_zero_r;
      sq_sd_r[0]   <= e_sd_r;
      dv_len_r[0]  <= len_c;
      dv_neg_r[0]  <= sq_neg_r[QS];
      dv_zero_r[0] <= sq_zero_r[QS];
      dv_sd_r[0]   <= sq_sd_r[QS];
      o_ok_r       <= !dv_zero_r[DS];
      o_sd_r       <= dv_sd_r[DS];
    end
  end

  for (genvar s = 0; s < QS; s++) begin : g_sq
    logic [LAV_SQ_W-1:0] x_c, q_c, b_c;

    always_comb begin
      x_c = sq_x_r[s];
      q_c = sq_q_r[s];
      b_c = '0;
      for (int j = 0; j < LAV_STEPS_PER; j++) begin
        b_c = LAV_SQ_W'(1) << (LAV_SQ_TOP - 2 * (s * LAV_STEPS_PER + j));
        if (x_c >= q_c + b_c) begin
          x_c = x_c - (q_c + b_c);
          q_c = (q_c >> 1) + b_c;
        end else begin
          q_c = q_c >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[s+1] <= 1'b0;
      end else if (en) begin
        sq_vld_r[s+1] <= sq_vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_x_r[s+1]    <= x_c;
        sq_q_r[s+1]    <= q_c;
        sq_m_r[s+1]    <= sq_m_r[s];
        sq_neg_r[s+1]  <= sq_neg_r[s];
        sq_zero_r[s+1] <= sq_zero_r[s];
        sq_sd_r[s+1]   <= sq_sd_r[s];
      end
    end
  end

  for (genvar s = 0; s < DS; s++) begin : g_div
    logic [NW-1:0] rem_c [3];
    logic [FB:0]   q_c   [3];
    logic [NW-1:0] sub_c;

    always_comb begin
      sub_c = '0;
      for (int i = 0; i < 3; i++) begin
        rem_c[i] = dv_rem_r[s][i];
        q_c[i]   = dv_q_r[s][i];
        for (int j = 0; j < LAV_STEPS_PER; j++) begin
          if (s * LAV_STEPS_PER + j <= FB) begin
            sub_c = NW'(dv_len_r[s]) << (FB - s * LAV_STEPS_PER - j);
            if (rem_c[i] >= sub_c) begin
              rem_c[i] = rem_c[i] - sub_c;
              q_c[i]   = {q_c[i][FB-1:0], 1'b1};
            end else begin
              q_c[i]   = {q_c[i][FB-1:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[s+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[s+1] <= dv_vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[s+1]  <= rem_c;
        dv_q_r[s+1]    <= q_c;
        dv_len_r[s+1]  <= dv_len_r[s];
        dv_neg_r[s+1]  <= dv_neg_r[s];
        dv_zero_r[s+1] <= dv_zero_r[s];
        dv_sd_r[s+1]   <= dv_sd_r[s];
      end
    end
  end

  assign out_vld  = o_vld_r;
  assign out_vec  = o_vec_r;
  assign out_ok   = o_ok_r;
  assign out_side = o_sd_r;

endmodule
